/* rtl/core/mbrr_pkg.sv */
package mbrr_pkg;

  // Size of the register table
  localparam int REGS = 2;
  localparam int IDX_W = (REGS > 1) ? $clog2(REGS) : 1;
  // Data bytes left in a response (two per register)
  localparam int REM_W = $clog2(2 * REGS + 1);

  localparam logic [7:0] ADDR_RESET      = 8'h02;
  localparam logic [7:0] FUNC_READ_HOLD  = 8'h03;
  localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0] EXC_FLAG        = 8'h80;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Exception codes
  typedef enum logic [1:0] {
    EXC_ILLEGAL_FUNC  = 2'd1,
    EXC_ILLEGAL_ADDR  = 2'd2,
    EXC_ILLEGAL_VALUE = 2'd3
  } exc_code_t;

  // Request byte slots
  typedef enum logic [2:0] {
    REQ_FUNC     = 3'd0,
    REQ_START_HI = 3'd1,
    REQ_START_LO = 3'd2,
    REQ_COUNT_HI = 3'd3,
    REQ_COUNT_LO = 3'd4,
    REQ_CRC_LO   = 3'd5
  } req_slot_t;

  // Source of a transmitted byte
  typedef enum logic [2:0] {
    SEL_ADDR     = 3'd0,
    SEL_FUNC     = 3'd1,
    SEL_CNT      = 3'd2,
    SEL_DATA     = 3'd3,
    SEL_CRC_LO   = 3'd4,
    SEL_CRC_HI   = 3'd5,
    SEL_EXC_FUNC = 3'd6,
    SEL_EXC_CODE = 3'd7
  } tx_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FUNC,
    ST_START_HI,
    ST_START_LO,
    ST_COUNT_HI,
    ST_COUNT_LO,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_TX_ADDR,
    ST_TX_FUNC,
    ST_TX_CNT,
    ST_TX_DATA,
    ST_TX_CRC_LO,
    ST_TX_CRC_HI,
    ST_TX_EXC_FUNC,
    ST_TX_EXC_CODE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic      tbl_wr;
    logic      req_wr;
    req_slot_t req_slot;
    logic      crc_start;
    logic      crc_feed;
    logic      set_code;
    exc_code_t code;
    logic      start_tx;
    logic      load;
    tx_sel_t   sel;
    logic      last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic addr_match;
    logic func_ok;
    logic crc_ok;
    logic start_bad;
    logic count_bad;
    logic data_last;
    logic out_free;
  } dp_stat_t;

  // CRC-16/Modbus update over one byte, reflected
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/modbus_rtu_read_register_responder_top.sv */
// Read-register responder for an RTU-style serial bus (functions 3 and 4).
// in_*  : one request per transfer. in_tuser = 0 carries a received serial byte
//         in in_tdata[7:0]; in_tuser = 1 writes in_tdata[24:9] into data
//         register in_tdata[8].
// out_* : one transmitted byte per transfer, out_tlast on the final byte of a
//         response or exception.
// cfg_* : writes the slave address; write it only while the block is idle.
// Response: once the request that completes a frame is accepted, the state
// register enters the transmit states and the first byte is loaded into the
// output register, then one byte per cycle while out_tready is high,
// 5 + 2*count bytes for a response, 2 bytes for an exception. A request that
// causes no response keeps in_tready high. in_tready is low while the transmit
// sequencer walks a response; it is high again as soon as the last byte sits
// in the output register, so the next request is taken while that byte waits.
// Reset (rst_n low, synchronous): idle frame state, slave address 2, register
// table zero, output empty.
// A stalled receiver holds the output register and pauses the sequencer.
module modbus_rtu_read_register_responder_top
  import mbrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] rx_byte, [8] reg_index, [24:9] reg_value
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [7:0] station_addr
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  mbrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mbrr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .rx_byte   (in_tdata[7:0]),
    .reg_index (in_tdata[8]),
    .reg_value (in_tdata[24:9]),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

  // Only an accepted serial byte can start a response
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready && !in_tuser))
    else $error("in_tready dropped without an accepted serial byte");

  // Requests resume only once the final byte is loaded
  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(in_tready)) |-> (out_tvalid && out_tlast))
    else $error("in_tready returned before the final byte was loaded");

  // A stalled byte stays put until it is taken
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output changed while stalled");

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

/* rtl/core/mbrr_ctrl.sv */
module mbrr_ctrl
  import mbrr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_op,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   rx_byte_fire;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Receive states take requests; transmit states walk the response
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.req_slot = REQ_FUNC;
    cmd.code     = EXC_ILLEGAL_FUNC;
    cmd.sel      = SEL_ADDR;
    in_tready    = 1'b0;
    rx_byte_fire = 1'b0;

    unique case (state_r)
      ST_IDLE, ST_FUNC, ST_START_HI, ST_START_LO,
      ST_COUNT_HI, ST_COUNT_LO, ST_CRC_LO, ST_CRC_HI: begin
        in_tready    = 1'b1;
        cmd.tbl_wr   = in_tvalid && in_op;
        rx_byte_fire = in_tvalid && !in_op;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase

    unique case (state_r)
      ST_IDLE: begin
        if (rx_byte_fire && stat.addr_match) begin
          cmd.crc_start = 1'b1;
          state_nxt     = ST_FUNC;
        end
      end
      ST_FUNC: begin
        if (rx_byte_fire) begin
          cmd.req_wr   = 1'b1;
          cmd.req_slot = REQ_FUNC;
          if (stat.func_ok) begin
            cmd.crc_feed = 1'b1;
            state_nxt    = ST_START_HI;
          end else begin
            cmd.set_code = 1'b1;
            cmd.code     = EXC_ILLEGAL_FUNC;
            state_nxt    = ST_TX_EXC_FUNC;
          end
        end
      end
      ST_START_HI: begin
        if (rx_byte_fire) begin
          cmd.req_wr   = 1'b1;
          cmd.req_slot = REQ_START_HI;
          cmd.crc_feed = 1'b1;
          state_nxt    = ST_START_LO;
        end
      end
      ST_START_LO: begin
        if (rx_byte_fire) begin
          cmd.req_wr   = 1'b1;
          cmd.req_slot = REQ_START_LO;
          cmd.crc_feed = 1'b1;
          state_nxt    = ST_COUNT_HI;
        end
      end
      ST_COUNT_HI: begin
        if (rx_byte_fire) begin
          cmd.req_wr   = 1'b1;
          cmd.req_slot = REQ_COUNT_HI;
          cmd.crc_feed = 1'b1;
          state_nxt    = ST_COUNT_LO;
        end
      end
      ST_COUNT_LO: begin
        if (rx_byte_fire) begin
          cmd.req_wr   = 1'b1;
          cmd.req_slot = REQ_COUNT_LO;
          cmd.crc_feed = 1'b1;
          state_nxt    = ST_CRC_LO;
        end
      end
      ST_CRC_LO: begin
        if (rx_byte_fire) begin
          cmd.req_wr   = 1'b1;
          cmd.req_slot = REQ_CRC_LO;
          state_nxt    = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        // Check the frame; a bad CRC is dropped silently
        if (rx_byte_fire) begin
          priority if (!stat.crc_ok) begin
            state_nxt = ST_IDLE;
          end else if (stat.start_bad) begin
            cmd.set_code = 1'b1;
            cmd.code     = EXC_ILLEGAL_ADDR;
            state_nxt    = ST_TX_EXC_FUNC;
          end else if (stat.count_bad) begin
            cmd.set_code = 1'b1;
            cmd.code     = EXC_ILLEGAL_VALUE;
            state_nxt    = ST_TX_EXC_FUNC;
          end else begin
            cmd.start_tx = 1'b1;
            state_nxt    = ST_TX_ADDR;
          end
        end
      end
      ST_TX_ADDR: begin
        cmd.sel = SEL_ADDR;
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TX_FUNC;
        end
      end
      ST_TX_FUNC: begin
        cmd.sel = SEL_FUNC;
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TX_CNT;
        end
      end
      ST_TX_CNT: begin
        cmd.sel = SEL_CNT;
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TX_DATA;
        end
      end
      ST_TX_DATA: begin
        cmd.sel = SEL_DATA;
        if (stat.out_free) begin
          cmd.load = 1'b1;
          if (stat.data_last) begin
            state_nxt = ST_TX_CRC_LO;
          end
        end
      end
      ST_TX_CRC_LO: begin
        cmd.sel = SEL_CRC_LO;
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TX_CRC_HI;
        end
      end
      ST_TX_CRC_HI: begin
        cmd.sel  = SEL_CRC_HI;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_TX_EXC_FUNC: begin
        cmd.sel = SEL_EXC_FUNC;
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TX_EXC_CODE;
        end
      end
      ST_TX_EXC_CODE: begin
        cmd.sel  = SEL_EXC_CODE;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

endmodule

/* rtl/core/mbrr_dp.sv */
module mbrr_dp
  import mbrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [7:0]  rx_byte,
  input  logic        reg_index,
  input  logic [15:0] reg_value,
  input  logic        cfg_wr,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic [7:0]       slave_addr_r;
  logic [15:0]      tbl_r [REGS];
  logic [7:0]       req_r [6];
  logic [15:0]      rx_crc_r;
  logic [15:0]      tx_crc_r;
  exc_code_t        code_r;
  logic [IDX_W-1:0] rp_r;
  logic             hi_r;
  logic [REM_W-1:0] rem_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [15:0]      start_w;
  logic [15:0]      count_w;
  logic [15:0]      rd_word;
  logic [7:0]       tx_byte;
  logic [IDX_W-1:0] wr_idx;

  assign start_w = {req_r[REQ_START_HI], req_r[REQ_START_LO]};
  assign count_w = {req_r[REQ_COUNT_HI], req_r[REQ_COUNT_LO]};
  assign wr_idx  = IDX_W'(reg_index);
  assign rd_word = tbl_r[rp_r];

  // Status toward the controller
  always_comb begin
    stat.addr_match = (rx_byte == slave_addr_r);
    stat.func_ok    = (rx_byte == FUNC_READ_HOLD) || (rx_byte == FUNC_READ_INPUT);
    stat.crc_ok     = ({rx_byte, req_r[REQ_CRC_LO]} == rx_crc_r);
    stat.start_bad  = (start_w >= 16'(REGS));
    stat.count_bad  = (count_w == 16'd0) ||
                      (({1'b0, start_w} + {1'b0, count_w}) > 17'(REGS));
    stat.data_last  = (rem_r == REM_W'(1));
    stat.out_free   = !out_valid_r || out_ready;
  end

  // Slave address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= ADDR_RESET;
    end else if (cfg_wr) begin
      slave_addr_r <= cfg_data;
    end
  end

  // Register table, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGS; i++) begin
        tbl_r[i] <= '0;
      end
    end else if (cmd.tbl_wr && (32'(reg_index) < REGS)) begin
      tbl_r[wr_idx] <= reg_value;
    end
  end

  // Request bytes
  always_ff @(posedge clk) begin
    if (cmd.req_wr) begin
      req_r[cmd.req_slot] <= rx_byte;
    end
  end

  // Receive CRC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_crc_r <= CRC_INIT;
    end else if (cmd.crc_start) begin
      rx_crc_r <= crc_feed(CRC_INIT, rx_byte);
    end else if (cmd.crc_feed) begin
      rx_crc_r <= crc_feed(rx_crc_r, rx_byte);
    end
  end

  // Exception code
  always_ff @(posedge clk) begin
    if (cmd.set_code) begin
      code_r <= cmd.code;
    end
  end

  // Byte select for the transmit side
  always_comb begin
    unique case (cmd.sel)
      SEL_ADDR:     tx_byte = slave_addr_r;
      SEL_FUNC:     tx_byte = req_r[REQ_FUNC];
      SEL_CNT:      tx_byte = {req_r[REQ_COUNT_LO][6:0], 1'b0};
      SEL_DATA:     tx_byte = hi_r ? rd_word[15:8] : rd_word[7:0];
      SEL_CRC_LO:   tx_byte = tx_crc_r[7:0];
      SEL_CRC_HI:   tx_byte = tx_crc_r[15:8];
      SEL_EXC_FUNC: tx_byte = req_r[REQ_FUNC] | EXC_FLAG;
      SEL_EXC_CODE: tx_byte = {6'd0, code_r};
      default:      tx_byte = 8'h00;
    endcase
  end

  // Transmit CRC and register walk
  always_ff @(posedge clk) begin
    if (cmd.start_tx) begin
      rp_r  <= start_w[IDX_W-1:0];
      hi_r  <= 1'b1;
      rem_r <= REM_W'({count_w, 1'b0});
    end else if (cmd.load && (cmd.sel == SEL_DATA)) begin
      hi_r  <= !hi_r;
      rem_r <= rem_r - REM_W'(1);
      if (!hi_r) begin
        rp_r <= rp_r + IDX_W'(1);
      end
    end
    if (cmd.load) begin
      if (cmd.sel == SEL_ADDR) begin
        tx_crc_r <= crc_feed(CRC_INIT, tx_byte);
      end else if ((cmd.sel == SEL_FUNC) || (cmd.sel == SEL_CNT) ||
                   (cmd.sel == SEL_DATA)) begin
        tx_crc_r <= crc_feed(tx_crc_r, tx_byte);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte_r <= tx_byte;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

/* tb/tb_modbus_rtu_read_register_responder_top.sv */
module tb_modbus_rtu_read_register_responder_top
  import mbrr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  SETTLE       = 8;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  PHASE_ITEMS  = 28;
  localparam bit  OP_RX_BYTE   = 1'b0;
  localparam bit  OP_REG_WRITE = 1'b1;

  // Frame tracking phases of the responder
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FUNC,
    PH_START_HI,
    PH_START_LO,
    PH_COUNT_HI,
    PH_COUNT_LO,
    PH_CRC_LO,
    PH_CRC_HI
  } frame_phase_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  // Responder model state
  logic [7:0]   slave_addr;
  frame_phase_t phase;
  logic [7:0]   req_bytes [6];
  logic [15:0]  crc_run;
  logic [15:0]  reg_table [REGS];

  // Transmit bytes still owed by the block
  logic [7:0] tx_byte_q [$];
  logic       tx_last_q [$];

  int  errors      = 0;
  int  cycles      = 0;
  int  items_sent  = 0;
  int  hold_left   = 0;
  bit  tx_no_gap   = 1'b0;
  bit  rx_no_stall = 1'b0;

  logic [7:0] want_byte;
  logic       want_last;

  modbus_rtu_read_register_responder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, a quiet mode, and long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (rx_no_stall) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 20);
    end
  end

  // Compare every transmitted byte with the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (tx_byte_q.size() == 0) begin
        $error("unexpected tx byte %02h last %0b", out_tdata, out_tlast);
        errors++;
      end else begin
        want_byte = tx_byte_q.pop_front();
        want_last = tx_last_q.pop_front();
        if (out_tdata !== want_byte) begin
          $error("tx_byte mismatch: expected %02h, actual %02h", want_byte, out_tdata);
          errors++;
        end
        if (out_tlast !== want_last) begin
          $error("last mismatch: expected %0b, actual %0b", want_last, out_tlast);
          errors++;
        end
      end
    end
  end

  // CRC-16 over one byte, reflected polynomial 0xA001
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] request_crc(input logic [7:0] a, input logic [7:0] fn,
                                              input logic [15:0] st, input logic [15:0] cnt);
    logic [15:0] c;
    c = crc16_byte(16'hFFFF, a);
    c = crc16_byte(c, fn);
    c = crc16_byte(c, st[15:8]);
    c = crc16_byte(c, st[7:0]);
    c = crc16_byte(c, cnt[15:8]);
    c = crc16_byte(c, cnt[7:0]);
    return c;
  endfunction

  function automatic void owe_byte(input logic [7:0] b, input logic last);
    tx_byte_q.push_back(b);
    tx_last_q.push_back(last);
  endfunction

  function automatic void owe_exception(input logic [7:0] fn, input exc_code_t code);
    owe_byte(fn | EXC_FLAG, 1'b0);
    owe_byte({6'b0, code}, 1'b1);
  endfunction

  // Last CRC byte arrived: check the frame and work out the reply
  function automatic void answer_frame(input logic [7:0] crc_hi);
    logic [15:0] got;
    int          start;
    int          count;
    logic [15:0] c;
    logic [7:0]  body [$];
    got   = {crc_hi, req_bytes[REQ_CRC_LO]};
    start = int'({req_bytes[REQ_START_HI], req_bytes[REQ_START_LO]});
    count = int'({req_bytes[REQ_COUNT_HI], req_bytes[REQ_COUNT_LO]});
    if (got != crc_run) return;
    if (start >= REGS) begin
      owe_exception(req_bytes[REQ_FUNC], EXC_ILLEGAL_ADDR);
      return;
    end
    if (count == 0 || start + count > REGS) begin
      owe_exception(req_bytes[REQ_FUNC], EXC_ILLEGAL_VALUE);
      return;
    end
    body.push_back(slave_addr);
    body.push_back(req_bytes[REQ_FUNC]);
    body.push_back(8'(count * 2));
    for (int r = start; r < start + count; r++) begin
      body.push_back(reg_table[r][15:8]);
      body.push_back(reg_table[r][7:0]);
    end
    c = 16'hFFFF;
    foreach (body[i]) begin
      c = crc16_byte(c, body[i]);
      owe_byte(body[i], 1'b0);
    end
    owe_byte(c[7:0], 1'b0);
    owe_byte(c[15:8], 1'b1);
  endfunction

  // Advance the responder model by one accepted request
  function automatic void respond_to_request(input bit op, input logic [7:0] b,
                                             input bit idx, input logic [15:0] val);
    if (op == OP_REG_WRITE) begin
      if (idx < REGS) reg_table[idx] = val;
      return;
    end
    case (phase)
      PH_IDLE: begin
        if (b == slave_addr) begin
          crc_run = crc16_byte(CRC_INIT, b);
          phase   = PH_FUNC;
        end
      end
      PH_FUNC: begin
        req_bytes[REQ_FUNC] = b;
        if (b != FUNC_READ_HOLD && b != FUNC_READ_INPUT) begin
          phase = PH_IDLE;
          owe_exception(b, EXC_ILLEGAL_FUNC);
        end else begin
          crc_run = crc16_byte(crc_run, b);
          phase   = PH_START_HI;
        end
      end
      PH_START_HI, PH_START_LO, PH_COUNT_HI, PH_COUNT_LO: begin
        req_bytes[int'(phase) - 1] = b;
        crc_run = crc16_byte(crc_run, b);
        phase   = frame_phase_t'(phase + 1);
      end
      PH_CRC_LO: begin
        req_bytes[REQ_CRC_LO] = b;
        phase = PH_CRC_HI;
      end
      default: begin
        phase = PH_IDLE;
        answer_frame(b);
      end
    endcase
  endfunction

  // Offer one request, with random gaps, and log it once it is taken
  task automatic send_req(input bit op, input logic [7:0] b, input bit idx,
                          input logic [15:0] val);
    while (!tx_no_gap && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, val, idx, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    respond_to_request(op, b, idx, val);
  endtask

  // Unused fields carry junk so they are shown to be ignored
  task automatic send_byte(input logic [7:0] b);
    send_req(OP_RX_BYTE, b, 1'($urandom), 16'($urandom));
  endtask

  task automatic send_update(input bit idx, input logic [15:0] val);
    send_req(OP_REG_WRITE, 8'($urandom), idx, val);
  endtask

  // Stop offering and let every owed byte come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tx_byte_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    slave_addr  = a;
  endtask

  // Full request frame; optional bad CRC, truncation and register updates between bytes
  task automatic send_frame(input logic [7:0] a, input logic [7:0] fn, input logic [15:0] st,
                            input logic [15:0] cnt, input bit bad_crc, input int nbytes,
                            input int upd_pct);
    logic [15:0] c;
    logic [7:0]  fr [8];
    c = request_crc(a, fn, st, cnt);
    if (bad_crc) c ^= 16'(1) << $urandom_range(15);
    fr = '{a, fn, st[15:8], st[7:0], cnt[15:8], cnt[7:0], c[7:0], c[15:8]};
    for (int k = 0; k < nbytes; k++) begin
      if ($urandom_range(99) < upd_pct) send_update(1'($urandom), 16'($urandom));
      send_byte(fr[k]);
    end
  endtask

  task automatic send_random_frame();
    logic [7:0]  a;
    logic [7:0]  fn;
    logic [15:0] st;
    logic [15:0] cnt;
    int          sel;
    a = slave_addr;
    if ($urandom_range(9) == 0) begin
      do a = 8'($urandom); while (a == slave_addr);
    end
    sel = $urandom_range(9);
    if (sel < 4) fn = FUNC_READ_HOLD;
    else if (sel < 8) fn = FUNC_READ_INPUT;
    else fn = 8'($urandom);
    st  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(2));
    cnt = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    send_frame(a, fn, st, cnt, $urandom_range(9) == 0,
               ($urandom_range(9) == 0) ? $urandom_range(1, 7) : 8, 12);
  endtask

  // Table extremes and a byte for some other slave
  task automatic test_updates_and_foreign();
    send_update(1'b0, 16'hFFFF);
    send_update(1'b1, 16'h0000);
    send_byte(8'hFF);
  endtask

  // Unknown function, then a new frame right behind the exception,
  // with a table update landing just before the last CRC byte
  task automatic test_illegal_function_then_read();
    logic [15:0] c;
    send_byte(ADDR_RESET);
    send_byte(8'h00);
    c = request_crc(ADDR_RESET, FUNC_READ_HOLD, 16'd0, 16'(REGS));
    send_byte(ADDR_RESET);
    send_byte(FUNC_READ_HOLD);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'(REGS));
    send_byte(c[7:0]);
    send_update(1'b1, 16'h8001);
    send_byte(c[15:8]);
  endtask

  // Start address at its maximum
  task automatic test_start_out_of_range();
    send_frame(ADDR_RESET, FUNC_READ_INPUT, 16'hFFFF, 16'd1, 1'b0, 8, 0);
  endtask

  // Address rewritten while a frame is half received
  task automatic test_address_change_mid_frame();
    logic [15:0] c;
    wait_drained();
    write_address(8'd247);
    c = request_crc(8'd247, FUNC_READ_HOLD, 16'd1, 16'd1);
    send_byte(8'd247);
    send_byte(FUNC_READ_HOLD);
    send_byte(8'h00);
    send_byte(8'h01);
    wait_drained();
    write_address(8'd1);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  // Random traffic in several address phases, with back-pressure and a quiet stretch
  task automatic test_random_traffic();
    logic [7:0] addrs [3];
    int         first;
    addrs = '{8'd1, 8'd247, 8'($urandom_range(1, 247))};
    foreach (addrs[p]) begin
      wait_drained();
      write_address(addrs[p]);
      tx_no_gap   = (p == 2);
      rx_no_stall = (p == 2);
      if (p == 1) hold_left = HOLD_CYCLES;
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) send_byte(8'($urandom));
        else send_random_frame();
        if (p == 0 && items_sent - first >= PHASE_ITEMS / 2 && tx_byte_q.size() != 0)
          wait_drained();
      end
    end
    tx_no_gap   = 1'b0;
    rx_no_stall = 1'b0;
  endtask

  initial begin
    slave_addr = ADDR_RESET;
    phase      = PH_IDLE;
    crc_run    = CRC_INIT;
    foreach (req_bytes[i]) req_bytes[i] = '0;
    foreach (reg_table[i]) reg_table[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_updates_and_foreign();
    test_illegal_function_then_read();
    test_start_out_of_range();
    test_address_change_mid_frame();
    test_random_traffic();

    wait_drained();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
